/* hw/rtl/fifo_queue_with_keyed_removal_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the keyed-removal order queue
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_KEYED_REMOVAL_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_KEYED_REMOVAL_CORE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define FKR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define FKR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/fkr_pkg.sv */
// ----------------------------------------------------------------------------
// fkr_pkg
// Widths, codes and shared types of the keyed-removal order queue.
// ----------------------------------------------------------------------------
package fkr_pkg;

   localparam int QueueDepth      = 64;
   localparam int CountWidth      = $clog2(QueueDepth + 1);

   localparam int ActionWidth     = 3;
   localparam int KeyWidth        = 64;
   localparam int QtyWidth        = 32;
   localparam int StatusWidth     = 2;
   localparam int EntryCountWidth = 7;
   localparam int SumWidth        = 38;

   localparam int ReqFieldWidth   = ActionWidth + KeyWidth + QtyWidth;
   localparam int ReqDataWidth    = ((ReqFieldWidth + 7) / 8) * 8;
   localparam int RspFieldWidth   = StatusWidth + KeyWidth + QtyWidth + EntryCountWidth
                                    + SumWidth;
   localparam int RspDataWidth    = ((RspFieldWidth + 7) / 8) * 8;

   localparam int RspKeyLsb       = StatusWidth;
   localparam int RspQtyLsb       = RspKeyLsb + KeyWidth;
   localparam int RspCountLsb     = RspQtyLsb + QtyWidth;
   localparam int RspSumLsb       = RspCountLsb + EntryCountWidth;

   typedef enum logic [ActionWidth-1:0] {
      ActAppend = 3'd0,
      ActTake   = 3'd1,
      ActRemove = 3'd2,
      ActLookup = 3'd3,
      ActClear  = 3'd4
   } action_type;

   typedef enum logic [StatusWidth-1:0] {
      StOk   = 2'd0,
      StMiss = 2'd1,
      StFull = 2'd2,
      StDup  = 2'd3
   } status_type;

   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [QueueDepth-1:0] pop_vec;
      logic                  clear;
      logic [KeyWidth-1:0]   key;
      logic [QtyWidth-1:0]   qty;
   } cell_cmd_type;

   typedef struct packed {
      logic [QueueDepth-1:0] used;
      logic [QueueDepth-1:0] match;
      logic [KeyWidth-1:0]   head_key;
      logic [QtyWidth-1:0]   head_qty;
      logic [QtyWidth-1:0]   match_qty;
   } cell_view_type;

endpackage

/* hw/rtl/fkr_cells.sv */
// ----------------------------------------------------------------------------
// fkr_cells
// Row of compacting queue cells, oldest item in cell 0, with a parallel
// key match across all cells.
// ----------------------------------------------------------------------------
module fkr_cells
   import fkr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   output cell_view_type view
);

   logic [QueueDepth-1:0] used_ff;
   logic [KeyWidth-1:0]   key_ff [QueueDepth];
   logic [QtyWidth-1:0]   qty_ff [QueueDepth];

   logic [QueueDepth-1:0] used_up;
   logic [KeyWidth-1:0]   key_up [QueueDepth];
   logic [QtyWidth-1:0]   qty_up [QueueDepth];
   logic [QueueDepth-1:0] free_vec;
   logic [QueueDepth-1:0] shift_vec;
   logic [QueueDepth-1:0] match_vec;
   logic [QtyWidth-1:0]   match_qty;

   assign used_up   = {1'b0, used_ff[QueueDepth-1:1]};
   assign free_vec  = ~used_ff & {used_ff[QueueDepth-2:0], 1'b1};
   assign shift_vec = cmd.pop ? ~(cmd.pop_vec - QueueDepth'(1)) : '0;

   always_comb begin
      key_up[QueueDepth-1] = '0;
      qty_up[QueueDepth-1] = '0;
      for (int i = 0; i < QueueDepth - 1; i++) begin
         key_up[i] = key_ff[i+1];
         qty_up[i] = qty_ff[i+1];
      end
   end

   always_comb begin
      match_qty = '0;
      for (int i = 0; i < QueueDepth; i++) begin
         match_vec[i] = used_ff[i] && (key_ff[i] == cmd.key);
         match_qty    = match_qty | (match_vec[i] ? qty_ff[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         used_ff <= '0;
      end else begin
         for (int i = 0; i < QueueDepth; i++) begin
            if (shift_vec[i]) begin
               used_ff[i] <= used_up[i];
            end else if (cmd.push && free_vec[i]) begin
               used_ff[i] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QueueDepth; i++) begin
         if (shift_vec[i]) begin
            key_ff[i] <= key_up[i];
            qty_ff[i] <= qty_up[i];
         end else if (cmd.push && free_vec[i]) begin
            key_ff[i] <= cmd.key;
            qty_ff[i] <= cmd.qty;
         end
      end
   end

   assign view.used      = used_ff;
   assign view.match     = match_vec;
   assign view.head_key  = key_ff[0];
   assign view.head_qty  = qty_ff[0];
   assign view.match_qty = match_qty;

endmodule

/* hw/rtl/fifo_queue_with_keyed_removal_core.sv */
// ----------------------------------------------------------------------------
// Keyed-removal order queue
// First-in first-out queue of order keys and quantities, with append,
// take head, remove by key, look up by key and clear.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one action item: action, order_key, order_quantity.
//   rsp_ returns exactly one result item per action: status, key and
//   quantity concerned, entry count and quantity total after the action.
//   An accepted item is held in the input register; it is then executed
//   against the cell row and its result loaded into the result register
//   once that register is empty or being read, and rsp_tvalid rises.
//   One item per cycle while rsp_tready is high: every cell compares its
//   key in parallel and the row compacts by one cell in the same cycle.
//   When rsp_tready is low the result register holds; one further item
//   waits in the input register, after which req_tready drops.
//   Reset empties the queue (count and total zero) and both registers;
//   the clear action does the same to the queue.
// ----------------------------------------------------------------------------
module fifo_queue_with_keyed_removal_core
   import fkr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // action, order_key, order_quantity
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // status, result_key, result_quantity, entry_count, quantity_total
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic                     in_valid_ff;
   logic [ActionWidth-1:0]   in_action_ff;
   logic [KeyWidth-1:0]      in_key_ff;
   logic [QtyWidth-1:0]      in_qty_ff;
   logic                     rsp_valid_ff;
   logic [RspDataWidth-1:0]  rsp_data_ff;
   logic [CountWidth-1:0]    count_ff;
   logic [SumWidth-1:0]      sum_ff;

   logic                     advance;
   logic                     req_take;
   action_type               act;
   status_type               status;
   logic [KeyWidth-1:0]      result_key;
   logic [QtyWidth-1:0]      result_qty;
   logic [CountWidth-1:0]    count_in;
   logic [SumWidth-1:0]      sum_in;
   logic [RspDataWidth-1:0]  rsp_data_in;
   cell_cmd_type             cmd_raw;
   cell_cmd_type             cmd;
   cell_view_type            view;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign act        = action_type'(in_action_ff);

   always_comb begin
      status         = StOk;
      result_key     = '0;
      result_qty     = '0;
      count_in       = count_ff;
      sum_in         = sum_ff;
      cmd_raw        = '0;
      cmd_raw.key    = in_key_ff;
      cmd_raw.qty    = in_qty_ff;
      unique case (act)
         ActAppend: begin
            if (view.used[QueueDepth-1]) begin
               status = StFull;
            end else if (|view.match) begin
               status     = StDup;
               result_key = in_key_ff;
               result_qty = view.match_qty;
            end else begin
               cmd_raw.push = 1'b1;
               result_key   = in_key_ff;
               result_qty   = in_qty_ff;
               count_in     = CountWidth'(count_ff + 1'b1);
               sum_in       = SumWidth'(sum_ff + SumWidth'(in_qty_ff));
            end
         end
         ActTake: begin
            if (!view.used[0]) begin
               status = StMiss;
            end else begin
               result_key      = view.head_key;
               result_qty      = view.head_qty;
               cmd_raw.pop     = 1'b1;
               cmd_raw.pop_vec = QueueDepth'(1);
               count_in        = CountWidth'(count_ff - 1'b1);
               sum_in          = SumWidth'(sum_ff - SumWidth'(view.head_qty));
            end
         end
         ActRemove, ActLookup: begin
            if (!(|view.match)) begin
               status = StMiss;
            end else begin
               result_key = in_key_ff;
               result_qty = view.match_qty;
               if (act == ActRemove) begin
                  cmd_raw.pop     = 1'b1;
                  cmd_raw.pop_vec = view.match;
                  count_in        = CountWidth'(count_ff - 1'b1);
                  sum_in          = SumWidth'(sum_ff - SumWidth'(view.match_qty));
               end
            end
         end
         ActClear: begin
            cmd_raw.clear = 1'b1;
            count_in      = '0;
            sum_in        = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd       = cmd_raw;
      cmd.push  = cmd_raw.push && advance;
      cmd.pop   = cmd_raw.pop && advance;
      cmd.clear = cmd_raw.clear && advance;
   end

   assign rsp_data_in = RspDataWidth'({sum_in, EntryCountWidth'(count_in), result_qty,
                                       result_key, status});

   fkr_cells u_cells (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .view  (view)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
            sum_ff       <= sum_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_tdata[ActionWidth-1:0];
         in_key_ff    <= req_tdata[ActionWidth +: KeyWidth];
         in_qty_ff    <= req_tdata[ActionWidth + KeyWidth +: QtyWidth];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/fkr_checker.sv */
// ----------------------------------------------------------------------------
// fkr_checker
// Port-level checks on the result channel of the keyed-removal order queue.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_keyed_removal_core_defines.svh"

module fkr_checker
   import fkr_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   logic [StatusWidth-1:0]     rsp_status;
   logic [KeyWidth-1:0]        rsp_key;
   logic [QtyWidth-1:0]        rsp_qty;
   logic [EntryCountWidth-1:0] rsp_count;

   assign rsp_status = rsp_tdata[StatusWidth-1:0];
   assign rsp_key    = rsp_tdata[RspKeyLsb +: KeyWidth];
   assign rsp_qty    = rsp_tdata[RspQtyLsb +: QtyWidth];
   assign rsp_count  = rsp_tdata[RspCountLsb +: EntryCountWidth];

   `FKR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result item changed while stalled")

   `FKR_ASSERT_SAME(a_full_count, clock, reset, rsp_tvalid && (rsp_status == StFull),
      rsp_count == EntryCountWidth'(QueueDepth), "full status with queue not full")

   `FKR_ASSERT_SAME(a_dup_nonempty, clock, reset, rsp_tvalid && (rsp_status == StDup),
      rsp_count != '0, "duplicate status on an empty queue")

   `FKR_ASSERT_SAME(a_miss_zero, clock, reset, rsp_tvalid && (rsp_status == StMiss),
      (rsp_key == '0) && (rsp_qty == '0), "miss status with non-zero entry")

endmodule

bind fifo_queue_with_keyed_removal_core fkr_checker u_fkr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
